FILE: rtl/abod_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abod_pkg
// shared types, register indexes and the 4x4 bayer matrix for the rgb565
// alpha blend and ordered dither block
// ----------------------------------------------------------------------------
package abod_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_BLEND_MODE      = 3'd0;
   localparam csr_index_type CSR_OVERLAY_RED     = 3'd1;
   localparam csr_index_type CSR_OVERLAY_GREEN   = 3'd2;
   localparam csr_index_type CSR_OVERLAY_BLUE    = 3'd3;
   localparam csr_index_type CSR_OVERLAY_ALPHA   = 3'd4;
   localparam csr_index_type CSR_DITHER_STRENGTH = 3'd5;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [15:0]       mix_sum_type;
   typedef logic [3:0]        bayer_type;

   // threshold matrix, indexed by {row, column}
   function automatic bayer_type bayer_lookup(input logic [1:0] row, input logic [1:0] col);
      bayer_type t;
      case ({row, col})
         4'd0:    t = 4'd0;
         4'd1:    t = 4'd8;
         4'd2:    t = 4'd2;
         4'd3:    t = 4'd10;
         4'd4:    t = 4'd12;
         4'd5:    t = 4'd4;
         4'd6:    t = 4'd14;
         4'd7:    t = 4'd6;
         4'd8:    t = 4'd3;
         4'd9:    t = 4'd11;
         4'd10:   t = 4'd1;
         4'd11:   t = 4'd9;
         4'd12:   t = 4'd15;
         4'd13:   t = 4'd7;
         4'd14:   t = 4'd13;
         4'd15:   t = 4'd5;
         default: t = 4'd0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/alpha_blend_ordered_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_ordered_dither
// rgb565 alpha blend followed by a 4x4 ordered dither and repack
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one destination pixel, its per-pixel source rgba and its
//   screen phase; rsp_result_pixel returns the blended, dithered pixel
//   both channels hand over a request when valid is high and stall is low
//   csr_write with csr_index/csr_data sets the six control registers; the
//   user must change them only while no request is in flight; unenforced
// timing:
//   three register stages (blend products, divide by 255 and dither offset,
//   dither add/clamp/pack into the output register); a request taken into
//   the blend product register passes the divide and output registers in
//   turn to rsp_*; one request per cycle is sustained while rsp_stall is
//   low, each stage being about one multiply-add deep
// stall:
//   each stage moves on when it is empty or the next stage moves, so bubbles
//   close up; a stalled result holds in the output register and req_stall
//   rises only once all three stages are full
// reset:
//   synchronous; clears all stage valid bits and every control register
// ----------------------------------------------------------------------------
module alpha_blend_ordered_dither
   import abod_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_dest_pixel,
   input  logic [7:0]            req_src_red,
   input  logic [7:0]            req_src_green,
   input  logic [7:0]            req_src_blue,
   input  logic [7:0]            req_src_alpha,
   input  logic [1:0]            req_x_phase,
   input  logic [1:0]            req_y_phase,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_W-1:0]    rsp_result_pixel
);

   // control registers
   logic     blend_mode_ff;
   chan_type overlay_red_ff, overlay_green_ff, overlay_blue_ff, overlay_alpha_ff;
   chan_type dither_strength_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff      <= 1'b0;
         overlay_red_ff     <= '0;
         overlay_green_ff   <= '0;
         overlay_blue_ff    <= '0;
         overlay_alpha_ff   <= '0;
         dither_strength_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BLEND_MODE:      blend_mode_ff      <= csr_data[0];
            CSR_OVERLAY_RED:     overlay_red_ff     <= csr_data;
            CSR_OVERLAY_GREEN:   overlay_green_ff   <= csr_data;
            CSR_OVERLAY_BLUE:    overlay_blue_ff    <= csr_data;
            CSR_OVERLAY_ALPHA:   overlay_alpha_ff   <= csr_data;
            CSR_DITHER_STRENGTH: dither_strength_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stage enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_en, s2_en, s3_en;

   assign s3_en     = !s3_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   // stage 1: expand, select source, blend products
   chan_type    dst_r, dst_g, dst_b, src_r, src_g, src_b, src_a, inv_a;
   mix_sum_type mix_r_in, mix_g_in, mix_b_in;
   mix_sum_type mix_r_ff, mix_g_ff, mix_b_ff;
   bayer_type   s1_thr_in, s1_thr_ff;

   always_comb begin
      dst_r = {req_dest_pixel[15:11], 3'b000};
      dst_g = {req_dest_pixel[10:5], 2'b00};
      dst_b = {req_dest_pixel[4:0], 3'b000};
      if (blend_mode_ff) begin
         src_r = req_src_red;
         src_g = req_src_green;
         src_b = req_src_blue;
         src_a = req_src_alpha;
      end else begin
         src_r = overlay_red_ff;
         src_g = overlay_green_ff;
         src_b = overlay_blue_ff;
         src_a = overlay_alpha_ff;
      end
      inv_a     = 8'd255 - src_a;
      mix_r_in  = 16'(16'(dst_r) * 16'(inv_a) + 16'(src_r) * 16'(src_a));
      mix_g_in  = 16'(16'(dst_g) * 16'(inv_a) + 16'(src_g) * 16'(src_a));
      mix_b_in  = 16'(16'(dst_b) * 16'(inv_a) + 16'(src_b) * 16'(src_a));
      s1_thr_in = bayer_lookup(req_y_phase, req_x_phase);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         mix_r_ff  <= mix_r_in;
         mix_g_ff  <= mix_g_in;
         mix_b_ff  <= mix_b_in;
         s1_thr_ff <= s1_thr_in;
      end
   end

   // stage 2: divide by 255, dither offset
   logic [16:0]        q_r, q_g, q_b;
   chan_type           bl_r_in, bl_g_in, bl_b_in, bl_r_ff, bl_g_ff, bl_b_ff;
   logic signed [8:0]  strength_s;
   logic signed [4:0]  thr_s;
   logic signed [13:0] offset_in, offset_ff;

   always_comb begin
      // exact floor(x / 255) for x below 65535
      q_r = 17'(mix_r_ff) + 17'd1 + 17'(mix_r_ff[15:8]);
      q_g = 17'(mix_g_ff) + 17'd1 + 17'(mix_g_ff[15:8]);
      q_b = 17'(mix_b_ff) + 17'd1 + 17'(mix_b_ff[15:8]);
      bl_r_in = q_r[15:8];
      bl_g_in = q_g[15:8];
      bl_b_in = q_b[15:8];
      strength_s = $signed({1'b0, dither_strength_ff});
      thr_s      = $signed({1'b0, s1_thr_ff}) - 5'sd8;
      offset_in  = strength_s * thr_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         bl_r_ff   <= bl_r_in;
         bl_g_ff   <= bl_g_in;
         bl_b_ff   <= bl_b_in;
         offset_ff <= offset_in;
      end
   end

   // stage 3: add offset, clamp, repack
   function automatic chan_type dither_clamp(input chan_type v, input logic signed [13:0] off);
      logic signed [13:0] s;
      chan_type           q;
      s = $signed({2'b00, v, 4'b0000}) + off;
      if (s[13]) begin
         q = '0;
      end else if (s[12]) begin
         q = 8'd255;
      end else begin
         q = s[11:4];
      end
      return q;
   endfunction

   chan_type             out_r, out_g, out_b;
   logic [PIXEL_W-1:0]   pixel_in, pixel_ff;

   always_comb begin
      out_r    = dither_clamp(bl_r_ff, offset_ff);
      out_g    = dither_clamp(bl_g_ff, offset_ff);
      out_b    = dither_clamp(bl_b_ff, offset_ff);
      pixel_in = {out_r[7:3], out_g[7:2], out_b[7:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid        = s3_valid_ff;
   assign rsp_result_pixel = pixel_ff;

endmodule
